// ===== design/isd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the impact spike detector: payload structs, register indexes,
// reset values and digit-serial sizing. No dependencies.
package isd_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned RUN_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned KMH_W      = 18;
  localparam int unsigned DIGIT_W    = 4;

  localparam int unsigned DIV_DIGITS   = 6;
  localparam int unsigned BLEND_DIGITS = 4;
  localparam int unsigned THR_DIGITS   = 5;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_ALPHA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED_KMH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN       = 3'd5;

  localparam logic [WEIGHT_W-1:0] RST_SMOOTH_ALPHA  = 17'd19661;
  localparam logic [WEIGHT_W-1:0] RST_FLOOR_ALPHA   = 17'd64880;
  localparam logic [DATA_W-1:0]   RST_SPIKE_LEVEL   = 16'd1229;
  localparam logic [DATA_W-1:0]   RST_SPEED_GAIN    = 16'd66;
  localparam logic [DATA_W-1:0]   RST_MIN_SPEED_KMH = 16'd1280;
  localparam logic [RUN_W-1:0]    RST_MIN_RUN       = 8'd2;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] iss;
    logic [DATA_W-1:0] speed;
  } isd_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] smoothed_out;
    logic [DATA_W-1:0] background_out;
    logic [DATA_W-1:0] excess_out;
    logic [DATA_W-1:0] threshold_out;
    logic              impact;
  } isd_out_t;

  function automatic logic [WEIGHT_W-1:0] clamp_weight(logic [WEIGHT_W-1:0] w);
    return (w > ONE_Q16) ? ONE_Q16 : w;
  endfunction

endpackage

// ===== design/impact_spike_detector.sv =====
`timescale 1ns / 1ps
// Impact spike detector: speed gated EMA smoothing, background tracking and
// speed adaptive thresholding. Depends on isd_pkg.
//
// A moving sample is worked one item at a time, the input stalled until its
// result is issued: six radix-16 digits of the km/h division by 5, then three
// passes of the shared 4-bit digit MAC (4, 4 and 5 digits). A sample below the
// speed floor skips the MAC passes and a clear command skips the division.
// Reset restores the register defaults and clears all filter state; the
// configuration port is always ready.
module impact_spike_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  isd_pkg::isd_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output isd_pkg::isd_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [isd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [isd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_GATE, S_SMOOTH, S_FLOOR, S_THR, S_FIN
  } state_e;

  state_e state_q;
  logic [2:0] cnt_q;

  logic [isd_pkg::WEIGHT_W-1:0] smooth_alpha_q, floor_alpha_q;
  logic [isd_pkg::DATA_W-1:0]   spike_level_q, speed_gain_q, min_speed_q;
  logic [isd_pkg::RUN_W-1:0]    min_run_q;

  logic [isd_pkg::DATA_W-1:0] sv_q, fv_q;
  logic [isd_pkg::RUN_W-1:0]  run_q;
  logic                       seeded_q;

  logic                       out_valid_q;
  isd_pkg::isd_out_t          out_data_q, res_q;

  logic [isd_pkg::DATA_W-1:0]   iss_q;
  logic [23:0]                  dq_q;
  logic [2:0]                   rem_q;
  logic [isd_pkg::WEIGHT_W-1:0] wa_q, wb_q;
  logic [19:0]                  sa_q, lo_q;
  logic [15:0]                  sb_q;
  logic [21:0]                  hi_q;

  logic [3:0]  div_qdig;
  logic [2:0]  div_rem;
  logic [20:0] dividend;
  logic [21:0] mac_sum, hi_d;
  logic [19:0] lo_d;
  logic [isd_pkg::KMH_W-1:0]    kmh;
  logic                         gate_low;
  logic [isd_pkg::WEIGHT_W-1:0] smooth_w, floor_w;
  logic [isd_pkg::DATA_W-1:0]   sv_eff, blend_res, floor_clip, thr;
  logic [21:0]                  rise;
  logic [22:0]                  thr_sum;
  logic [isd_pkg::RUN_W-1:0]    run_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [3:0] t;
    logic [2:0] r;
    r = rem_q;
    div_qdig = '0;
    for (int i = 0; i < isd_pkg::DIGIT_W; i++) begin
      t = {r, dq_q[23-i]};
      if (t >= 4'd5) begin
        div_qdig[3-i] = 1'b1;
        r = 3'(t - 4'd5);
      end else begin
        r = t[2:0];
      end
    end
    div_rem = r;
  end

  assign dividend = {1'b0, in_data_i.speed, 4'b0} + {4'b0, in_data_i.speed, 1'b0} + 21'd2;

  assign mac_sum = hi_q + 22'(wa_q) * 22'(sa_q[3:0]) + 22'(wb_q) * 22'(sb_q[3:0]);
  assign hi_d    = 22'(mac_sum[21:4]);
  assign lo_d    = {mac_sum[3:0], lo_q[19:4]};

  assign kmh      = dq_q[isd_pkg::KMH_W-1:0];
  assign gate_low = kmh < {2'b0, min_speed_q};
  assign smooth_w = isd_pkg::clamp_weight(smooth_alpha_q);
  assign floor_w  = isd_pkg::clamp_weight(floor_alpha_q);
  assign sv_eff   = seeded_q ? sv_q : iss_q;

  assign blend_res  = (hi_d[21:16] != '0) ? '1 : hi_d[15:0];
  assign floor_clip = (blend_res > sv_q) ? sv_q : blend_res;

  assign rise     = {hi_d[13:0], lo_d[19:12]};
  assign thr_sum  = {7'b0, spike_level_q} + {1'b0, rise};
  assign thr      = (thr_sum[22:16] != '0) ? '1 : thr_sum[15:0];
  assign run_next = (res_q.excess_out >= thr)
                  ? ((run_q == '1) ? run_q : run_q + 8'd1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_alpha_q <= isd_pkg::RST_SMOOTH_ALPHA;
      floor_alpha_q  <= isd_pkg::RST_FLOOR_ALPHA;
      spike_level_q  <= isd_pkg::RST_SPIKE_LEVEL;
      speed_gain_q   <= isd_pkg::RST_SPEED_GAIN;
      min_speed_q    <= isd_pkg::RST_MIN_SPEED_KMH;
      min_run_q      <= isd_pkg::RST_MIN_RUN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        isd_pkg::REG_SMOOTH_ALPHA:  smooth_alpha_q <= cfg_data_i;
        isd_pkg::REG_FLOOR_ALPHA:   floor_alpha_q  <= cfg_data_i;
        isd_pkg::REG_SPIKE_LEVEL:   spike_level_q  <= cfg_data_i[15:0];
        isd_pkg::REG_SPEED_GAIN:    speed_gain_q   <= cfg_data_i[15:0];
        isd_pkg::REG_MIN_SPEED_KMH: min_speed_q    <= cfg_data_i[15:0];
        isd_pkg::REG_MIN_RUN:       min_run_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sv_q        <= '0;
      fv_q        <= '0;
      run_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) begin
            if (in_data_i.command) begin
              sv_q     <= '0;
              fv_q     <= '0;
              run_q    <= '0;
              seeded_q <= 1'b0;
              res_q    <= '0;
              state_q  <= S_FIN;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'(isd_pkg::DIV_DIGITS - 1)) begin
            state_q <= S_GATE;
          end
        end
        S_GATE: begin
          cnt_q <= '0;
          if (gate_low) begin
            run_q   <= '0;
            res_q   <= isd_pkg::isd_out_t'{'0, fv_q, '0, '0, 1'b0};
            state_q <= S_FIN;
          end else begin
            if (!seeded_q) begin
              sv_q     <= iss_q;
              fv_q     <= iss_q;
              seeded_q <= 1'b1;
            end
            state_q <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          if (cnt_q == 3'(isd_pkg::BLEND_DIGITS - 1)) begin
            cnt_q   <= '0;
            sv_q    <= blend_res;
            state_q <= S_FLOOR;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_FLOOR: begin
          if (cnt_q == 3'(isd_pkg::BLEND_DIGITS - 1)) begin
            cnt_q            <= '0;
            fv_q             <= floor_clip;
            res_q.excess_out <= sv_q - floor_clip;
            state_q          <= S_THR;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_THR: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'(isd_pkg::THR_DIGITS - 1)) begin
            run_q   <= run_next;
            res_q   <= isd_pkg::isd_out_t'{sv_q, fv_q, res_q.excess_out, thr,
                                           run_next >= min_run_q};
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        iss_q <= in_data_i.iss;
        dq_q  <= {3'b0, dividend};
        rem_q <= '0;
      end
      S_DIV: begin
        dq_q  <= {dq_q[19:0], div_qdig};
        rem_q <= div_rem;
      end
      S_GATE: begin
        wa_q <= smooth_w;
        wb_q <= isd_pkg::ONE_Q16 - smooth_w;
        sa_q <= {4'b0, iss_q};
        sb_q <= sv_eff;
        hi_q <= 22'd32768;
        lo_q <= '0;
      end
      S_SMOOTH, S_FLOOR, S_THR: begin
        if (state_q == S_SMOOTH && cnt_q == 3'(isd_pkg::BLEND_DIGITS - 1)) begin
          wa_q <= floor_w;
          wb_q <= isd_pkg::ONE_Q16 - floor_w;
          sa_q <= {4'b0, fv_q};
          sb_q <= blend_res;
          hi_q <= 22'd32768;
          lo_q <= '0;
        end else if (state_q == S_FLOOR && cnt_q == 3'(isd_pkg::BLEND_DIGITS - 1)) begin
          wa_q <= {1'b0, speed_gain_q};
          wb_q <= '0;
          sa_q <= {2'b0, kmh};
          sb_q <= '0;
          hi_q <= 22'd2048;
          lo_q <= '0;
        end else begin
          hi_q <= hi_d;
          lo_q <= lo_d;
          sa_q <= {4'b0, sa_q[19:4]};
          sb_q <= {4'b0, sb_q[15:4]};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/isd_checker.sv =====
`timescale 1ns / 1ps
// Port level checks for the impact spike detector, bound to the top level.
// Depends on isd_pkg and impact_spike_detector.
module isd_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input isd_pkg::isd_out_t              out_data_o
);

  // Items are worked one at a time, so an input transfer stalls the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

  // The background is clamped to the smoothed value, so the parts add up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.smoothed_out != '0) |->
      ({1'b0, out_data_o.excess_out} + {1'b0, out_data_o.background_out}
        == {1'b0, out_data_o.smoothed_out}))
    else $error("excess and background do not add up to smoothed value");

endmodule

bind impact_spike_detector isd_port_checker u_isd_port_checker (.*);
